/* rtl/core/sha_pkg.sv */
`timescale 1ns / 1ps

package sha_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [7:0]  t_chain;
    typedef t_word [15:0] t_block;

    typedef struct packed {
        logic start;
        logic chain_init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam logic [7:0] C_PAD_BYTE = 8'h80;
    localparam logic [5:0] C_LEN_POS  = 6'd56;

    localparam t_chain C_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word f_bsig0(t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word f_bsig1(t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word f_ssig0(t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word f_ssig1(t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic t_word f_round_k(logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/sha_core.sv */
`timescale 1ns / 1ps

module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    input  sha_pkg::t_block    i_block,
    output sha_pkg::t_core_sts o_sts,
    output sha_pkg::t_chain    o_chain
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FINAL = 3'b100
    } t_core_state;

    t_core_state     r_state;
    logic [5:0]      r_round;
    logic            r_done;
    sha_pkg::t_chain r_chain;
    sha_pkg::t_chain r_v;
    sha_pkg::t_block r_w;

    sha_pkg::t_chain n_v;
    sha_pkg::t_block n_w;
    sha_pkg::t_word  n_t1;
    sha_pkg::t_word  n_t2;
    sha_pkg::t_word  n_ch;
    sha_pkg::t_word  n_maj;

    always_comb begin
        n_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        n_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        n_t1  = r_v[7] + sha_pkg::f_bsig1(r_v[4]) + n_ch + sha_pkg::f_round_k(r_round) + r_w[0];
        n_t2  = sha_pkg::f_bsig0(r_v[0]) + n_maj;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + n_t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = n_t1 + n_t2;
        for (int i = 0; i < 15; i++) begin
            n_w[i] = r_w[i + 1];
        end
        n_w[15] = r_w[0] + sha_pkg::f_ssig0(r_w[1]) + r_w[9] + sha_pkg::f_ssig1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
            r_chain <= sha_pkg::C_IV;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctl.chain_init) begin
                        r_chain <= sha_pkg::C_IV;
                    end
                    if (i_ctl.start) begin
                        r_w     <= i_block;
                        r_v     <= r_chain;
                        r_round <= '0;
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_v     <= n_v;
                    r_w     <= n_w;
                    r_round <= r_round + 6'd1;
                    if (&r_round) begin
                        r_state <= C_FINAL;
                    end
                end
                C_FINAL: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_sts.done = r_done;
    assign o_chain    = r_chain;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == C_IDLE))
        else $error("start while compressing");

    a_round_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_ROUND) && (&r_round) |=> (r_state == C_FINAL))
        else $error("round 63 not followed by chain update");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == C_IDLE))
        else $error("done while busy");

endmodule

/* rtl/core/sha256_stream_hasher_top.sv */
`timescale 1ns / 1ps
// Input beat: accepted while idle. A beat that completes a 64-byte block holds the input off for
// its compression (start, load, 64 rounds, chain update, return to idle).
// Last beat: a padding step, then 1 or 2 block compressions, then 8 output beats.
// Throughput is set by the shared round unit: one SHA-256 round per clock.
// Reset (synchronous, active low): chaining state to the initial hash, length and position
// to zero, no output pending. State also returns to reset after the eighth digest beat.

module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] byte_present
    input  logic        s_axis_tlast,  // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,  // [2:0] word_number
    output logic        m_axis_tlast   // final_word
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state;
    sha_pkg::t_block    r_block;
    logic [63:0]        r_bitlen;
    logic [5:0]         r_pos;
    logic               r_last;
    logic               r_len_next;
    logic               r_final;
    logic [2:0]         r_cnt;
    sha_pkg::t_core_ctl r_ctl;

    sha_pkg::t_core_sts w_sts;
    sha_pkg::t_chain    w_chain;

    sha_pkg::t_block    n_pad;
    sha_pkg::t_word     n_byte_word;
    logic               n_in_beat;
    logic               n_out_beat;
    logic               n_len_fits;

    function automatic sha_pkg::t_word f_put_byte(sha_pkg::t_word w, logic [1:0] lane,
                                                  logic [7:0] b);
        sha_pkg::t_word r;
        r = w;
        case (lane)
            2'd0:    r = {b, 24'h0};
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8] = b;
            default: r[7:0] = b;
        endcase
        return r;
    endfunction

    assign n_in_beat   = s_axis_tvalid && s_axis_tready;
    assign n_out_beat  = m_axis_tvalid && m_axis_tready;
    assign n_len_fits  = (r_pos < sha_pkg::C_LEN_POS);
    assign n_byte_word = f_put_byte(r_block[r_pos[5:2]], r_pos[1:0], s_axis_tdata);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (4'(i) > r_pos[5:2]) begin
                n_pad[i] = '0;
            end else if (4'(i) == r_pos[5:2]) begin
                n_pad[i] = f_put_byte(r_block[i], r_pos[1:0], sha_pkg::C_PAD_BYTE);
            end else begin
                n_pad[i] = r_block[i];
            end
        end
        if (n_len_fits) begin
            n_pad[14] = r_bitlen[63:32];
            n_pad[15] = r_bitlen[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bitlen   <= '0;
            r_pos      <= '0;
            r_last     <= 1'b0;
            r_len_next <= 1'b0;
            r_final    <= 1'b0;
            r_cnt      <= '0;
            r_ctl      <= '0;
        end else begin
            r_ctl <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_beat) begin
                        r_last <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_block[r_pos[5:2]] <= n_byte_word;
                            r_pos               <= r_pos + 6'd1;
                            r_bitlen            <= r_bitlen + 64'd8;
                        end
                        if (s_axis_tuser && (&r_pos)) begin
                            r_ctl.start <= 1'b1;
                            r_state     <= S_COMP;
                        end else if (s_axis_tlast) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_block     <= n_pad;
                    r_ctl.start <= 1'b1;
                    r_last      <= 1'b0;
                    if (n_len_fits) begin
                        r_final <= 1'b1;
                    end else begin
                        r_len_next <= 1'b1;
                    end
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (w_sts.done) begin
                        if (r_len_next) begin
                            for (int i = 0; i < 14; i++) begin
                                r_block[i] <= '0;
                            end
                            r_block[14] <= r_bitlen[63:32];
                            r_block[15] <= r_bitlen[31:0];
                            r_ctl.start <= 1'b1;
                            r_len_next  <= 1'b0;
                            r_final     <= 1'b1;
                        end else if (r_final) begin
                            r_final <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end else if (r_last) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (n_out_beat) begin
                        r_cnt <= r_cnt + 3'd1;
                        if (&r_cnt) begin
                            r_ctl.chain_init <= 1'b1;
                            r_pos            <= '0;
                            r_bitlen         <= '0;
                            r_state          <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_block (r_block),
        .o_sts   (w_sts),
        .o_chain (w_chain)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = w_chain[r_cnt];
    assign m_axis_tuser  = r_cnt;
    assign m_axis_tlast  = (&r_cnt);

    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_axis_tready, m_axis_tvalid}))
        else $error("input and output open together");

    a_out_core_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_sts.busy)
        else $error("digest shown while compressing");

    a_last_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_out_beat && m_axis_tlast |=> s_axis_tready && (r_pos == 6'd0))
        else $error("no return to idle after digest");

    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_COMP))
        else $error("compression finished outside wait state");

endmodule
